>>> hw/rtl/bcdrp_pkg.sv
// Shared constants, types and helpers for the BCD running product block.
package bcdrp_pkg;

  localparam int unsigned NIBBLES = 16;
  localparam int unsigned COLS    = 2 * NIBBLES + 2;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_MUL   = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ROW    = 4'b0010,
    ST_SETTLE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  // Quotient by ten for an 8-bit column value below 160 (4-bit result), by reciprocal multiply.
  function automatic logic [3:0] div10(input logic [7:0] x);
    logic [18:0] p;
    p = 19'(x) * 19'd205;
    return p[14:11];
  endfunction

endpackage

>>> hw/rtl/bcdrp_lane.sv
// One column lane: keep the column digit, take the carry and one partial product.
module bcdrp_lane import bcdrp_pkg::*; (
  input  logic [7:0] col,
  input  logic [3:0] carry_in,
  input  logic [3:0] a_digit,
  input  logic [3:0] m_digit,
  input  logic       add_en,
  output logic [3:0] carry_out,
  output logic [7:0] col_nxt
);

  logic [7:0] prod;
  logic [3:0] rem;

  // Split the column into carry and kept digit
  assign carry_out = div10(col);
  assign rem       = 4'(col - 8'(carry_out) * 8'd10);
  assign prod      = add_en ? (8'(a_digit) * 8'(m_digit)) : 8'd0;
  assign col_nxt   = 8'(rem) + 8'(carry_in) + prod;

endmodule

>>> hw/rtl/bcd_running_product_core.sv
// Top level: running BCD product with one lane per result column.
// Usage: in_valid/in_stall carry an item (operation, operand_bcd); out_valid/
// out_stall carry the result (product_bcd, digit_count, overflow).
// An item is taken only while the block is idle: in_stall is high from the
// cycle after acceptance until its result is loaded into the output register.
// A multiply item adds one operand-digit row per cycle across the column
// lanes, one row per operand digit, then a settle phase runs until no column
// holds a carry, then the columns are merged into the result as it loads
// into the output register. A start item skips the rows.
// The output register holds a finished result while out_stall is high; the
// next item can be accepted meanwhile, but its result waits for the register.
// Reset returns the accumulator to BCD one and clears the output valid flag.
module bcd_running_product_core import bcdrp_pkg::*; #(
  parameter int unsigned DIGITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [63:0] in_operand_bcd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_product_bcd,
  output logic [4:0]  out_digit_count,
  output logic        out_overflow
);

  state_t            state_r;
  logic [3:0]        row_r;
  logic [63:0]       operand_r;
  logic [63:0]       acc_r;
  logic [4*COLS-1:0] a_sh_r;
  logic [7:0]        col_r   [COLS];
  logic [7:0]        col_nxt [COLS];
  logic [3:0]        carry   [COLS];
  logic [3:0]        m_digit;
  logic              add_en;
  logic              any_carry;
  logic              out_valid_r;
  logic [63:0]       prod_nxt;
  logic [4:0]        cnt_nxt;
  logic              ovf_nxt;
  logic              load_out;
  logic              accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign m_digit  = operand_r[4*row_r +: 4];
  assign add_en   = (state_r == ST_ROW);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Column lanes
  for (genvar c = 0; c < COLS; c++) begin : g_lane
    bcdrp_lane u_lane (
      .col      (col_r[c]),
      .carry_in ((c == 0) ? 4'd0 : carry[(c == 0) ? 0 : c - 1]),
      .a_digit  (a_sh_r[4*c +: 4]),
      .m_digit  (m_digit),
      .add_en   (add_en),
      .carry_out(carry[c]),
      .col_nxt  (col_nxt[c])
    );
  end

  // Detect pending carries
  always_comb begin
    any_carry = 1'b0;
    for (int c = 0; c < COLS; c++) begin
      if (carry[c] != 4'd0) any_carry = 1'b1;
    end
  end

  // Merge columns into the result
  always_comb begin
    prod_nxt = '0;
    cnt_nxt  = '0;
    ovf_nxt  = 1'b0;
    for (int c = 0; c < COLS; c++) begin
      if (c < DIGITS) begin
        prod_nxt[4*c +: 4] = col_r[c][3:0];
        if (col_r[c] != 8'd0) cnt_nxt = 5'(c + 1);
      end else if (col_r[c] != 8'd0) begin
        ovf_nxt = 1'b1;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      acc_r   <= 64'd1;
      row_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            row_r <= '0;
            if (op_t'(in_operation) == OP_MUL) state_r <= ST_ROW;
            else                               state_r <= ST_SETTLE;
          end
        end
        ST_ROW: begin
          row_r <= row_r + 4'd1;
          if (row_r == 4'(NIBBLES - 1)) state_r <= ST_SETTLE;
        end
        ST_SETTLE: begin
          if (!any_carry) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            acc_r   <= prod_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Column and shifted-multiplicand datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      operand_r <= in_operand_bcd;
      a_sh_r    <= {{(4*COLS-64){1'b0}}, acc_r};
      for (int c = 0; c < COLS; c++) begin
        col_r[c] <= ((c == 0) && (op_t'(in_operation) == OP_START)) ? 8'd1 : 8'd0;
      end
    end else if (state_r == ST_ROW || state_r == ST_SETTLE) begin
      for (int c = 0; c < COLS; c++) col_r[c] <= col_nxt[c];
      if (state_r == ST_ROW) a_sh_r <= {a_sh_r[4*COLS-5:0], 4'd0};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_product_bcd <= prod_nxt;
      out_digit_count <= cnt_nxt;
      out_overflow    <= ovf_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> dv/bcd_running_product_checker.sv
// Result checker for the BCD running product block: tracks items, predicts and compares.
`timescale 1ns / 100ps
module bcd_running_product_checker import bcdrp_pkg::*; #(
  parameter int unsigned DIGITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_operation,
  input  logic [63:0] in_operand_bcd,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_product_bcd,
  input  logic [4:0]  out_digit_count,
  input  logic        out_overflow,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [63:0] product;
    logic [4:0]  count;
    logic        ovf;
  } product_t;

  product_t    expected_products[$];
  logic [63:0] running_acc;

  // Count significant digits of a packed BCD value within the kept width.
  function automatic logic [4:0] sig_digits(input logic [63:0] v);
    logic [4:0] n;
    n = 0;
    for (int i = 0; i < DIGITS && i < 16; i++)
      if (v[4*i +: 4] != 4'd0) n = 5'(i + 1);
    return n;
  endfunction

  // Schoolbook multiply of the running value by one operand, with decimal carries.
  function automatic product_t multiply_bcd(input logic [63:0] acc, input logic [63:0] opnd,
                                            inout logic [63:0] next_acc);
    int unsigned col [36];
    product_t    r;
    logic [63:0] res;
    res = 0;
    r.ovf = 1'b0;
    for (int i = 0; i < 36; i++) col[i] = 0;
    for (int j = 0; j < 16; j++)
      for (int i = 0; i < 16 && i < DIGITS; i++)
        col[i+j] += acc[4*i +: 4] * opnd[4*j +: 4];
    for (int i = 0; i < 35; i++) begin
      col[i+1] += col[i] / 10;
      col[i] = col[i] % 10;
    end
    for (int i = 0; i < 36; i++) begin
      if (i < DIGITS && i < 16) res[4*i +: 4] = 4'(col[i]);
      else if (col[i] != 0) r.ovf = 1'b1;
    end
    next_acc = res;
    r.product = res;
    r.count = sig_digits(res);
    return r;
  endfunction

  assign pending_count = expected_products.size();

  // Predict on accepted input items, compare on accepted result items.
  always @(posedge clk) begin
    product_t e;
    logic [63:0] nxt;
    if (!rst_n) begin
      running_acc <= 64'd1;
      fail_count <= 0;
      expected_products.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (op_t'(in_operation) == OP_START) begin
          e.product = 64'd1; e.count = 5'd1; e.ovf = 1'b0;
          running_acc <= 64'd1;
        end else begin
          e = multiply_bcd(running_acc, in_operand_bcd, nxt);
          running_acc <= nxt;
        end
        expected_products.push_back(e);
      end
      if (out_valid && !out_stall) begin
        if (expected_products.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item %h", out_product_bcd);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_products.pop_front();
          if (e.product !== out_product_bcd || e.count !== out_digit_count ||
              e.ovf !== out_overflow) begin
            if (fail_count < 10)
              $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d", e.product, e.count,
                       e.ovf, out_product_bcd, out_digit_count, out_overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> dv/bcd_running_product_core_test.sv
// Testbench top for the BCD running product block: stimulus, backpressure and verdict.
`timescale 1ns / 100ps
module bcd_running_product_core_test;
  import bcdrp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [63:0] in_operand_bcd;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_product_bcd;
  logic [4:0]  out_digit_count;
  logic        out_overflow;
  int          fail_count;
  int          pending_count;
  int          cycle_count;
  logic        quiet_phase;
  logic        hold_off_req;
  logic        hold_off_active;

  bcd_running_product_core u_dut (.*);

  bcd_running_product_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Random digit string with the given number of digits, other nibbles zero.
  function automatic logic [63:0] rand_bcd(input int ndig);
    logic [63:0] v;
    v = 0;
    for (int i = 0; i < ndig; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
    return v;
  endfunction

  // Offer one item and hold it until accepted; gaps come before it.
  task automatic send_item(input op_t op, input logic [63:0] opnd);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_operand_bcd <= opnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Receiver stalls: random bursts, one long hold-off on request.
  initial begin
    int burst;
    out_stall = 1'b0;
    hold_off_active = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_active <= 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_off_active <= 1'b0;
        @(posedge clk);
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // Time limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] v;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_operand_bcd = 64'd0;
    quiet_phase = 1'b0;
    hold_off_req = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset value, extremes, nibbles above nine, zero factor, overflow.
    send_item(OP_MUL, 64'h2);
    send_item(OP_MUL, 64'h9999_9999_9999_9999);
    send_item(OP_MUL, 64'h9999_9999_9999_9999);
    send_item(OP_START, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_MUL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_START, 64'h0);
    send_item(OP_MUL, 64'hF);
    send_item(OP_MUL, 64'hABCD);
    send_item(OP_MUL, 64'h1000_0000_0000_0000);
    send_item(OP_START, 64'h0);
    send_item(OP_MUL, 64'h5555_5555_5555_5555);
    send_item(OP_MUL, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_START, 64'h0);
    send_item(OP_MUL, 64'h0);
    send_item(OP_MUL, 64'h7);
    send_item(OP_START, 64'h0);
    send_item(OP_MUL, 64'h1234_5678);
    send_item(OP_MUL, 64'h8765_4321);
    send_item(OP_MUL, 64'h1);

    // Sender pause until every result is back.
    drain_all();

    // Long receiver hold-off while the sender keeps offering.
    hold_off_req <= 1'b1;
    @(posedge clk);
    while (!hold_off_active) @(posedge clk);
    hold_off_req <= 1'b0;
    for (int k = 0; k < 6; k++) send_item(OP_MUL, rand_bcd($urandom_range(1, 3)));

    // Random: mostly sequences from one with small operands, some wide noise.
    for (int n = 0; n < 1130; n++) begin
      if (n >= 1000) quiet_phase <= 1'b1;
      case ($urandom_range(0, 9))
        0: send_item(OP_START, {$urandom, $urandom});
        1: send_item(OP_MUL, {$urandom, $urandom});
        2: send_item(OP_MUL, 64'h0);
        3: send_item(OP_MUL, rand_bcd($urandom_range(1, 16)));
        default: begin
          v = rand_bcd($urandom_range(1, 3));
          if ($urandom_range(0, 15) == 0) v[3:0] = 4'($urandom_range(10, 15));
          send_item(OP_MUL, v);
        end
      endcase
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bcdrp_pkg.sv
hw/rtl/bcdrp_lane.sv
hw/rtl/bcd_running_product_core.sv
dv/bcd_running_product_checker.sv
dv/bcd_running_product_core_test.sv
